@@ sv/tht_pkg.sv @@
// Package: shared types and default sizes for the TCP handshake tracker.
`timescale 1ns / 1ps
`default_nettype none
package tht_pkg;

	localparam int unsigned CONN_ENTRIES_DEF = 256;
	localparam int unsigned FAIL_ENTRIES_DEF = 256;

	typedef enum logic [1:0] {
		PH_REQ   = 2'd0,
		PH_REPLY = 2'd1,
		PH_EST   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_EST       = 3'd1,
		EV_FAIL      = 3'd2,
		EV_CONN_FULL = 3'd3,
		EV_FAIL_FULL = 3'd4
	} event_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CSCAN = 5'b00010,
		S_CDEC  = 5'b00100,
		S_FSCAN = 5'b01000,
		S_FDEC  = 5'b10000
	} state_t;

	typedef struct packed {
		logic [63:0] addrs;
		logic [31:0] ports;
		phase_t      phase;
	} conn_entry_t;

	typedef struct packed {
		logic [63:0] addrs;
		logic [15:0] port;
		logic [31:0] count;
	} fail_entry_t;

endpackage
`default_nettype wire

@@ sv/tcp_handshake_tracker.sv @@
// Top level: TCP three-way handshake tracker with connection and failure tables.
//
//  channel   | handshake         | payload
//  ----------+-------------------+------------------------------------------------
//  command   | start / busy      | src_addr dst_addr src_port dst_port syn_flag
//            |                   | ack_flag
//  result    | done (1 cycle)    | event_res client_addr client_port server_addr
//            |                   | server_port fail_total
//
// An item scans the connection table, and the failure table as well when it fails.
// The scan loop reads one table entry from that table's single memory read port and
// matches it per cycle.
// Reset clears the used bits of both tables; no clearing pass is needed.
// The receiver cannot stall: done is high for one cycle with the result.
`timescale 1ns / 1ps
`default_nettype none
module tcp_handshake_tracker
	import tht_pkg::*;
#(
	parameter int unsigned CONN_ENTRIES = CONN_ENTRIES_DEF,
	parameter int unsigned FAIL_ENTRIES = FAIL_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] src_addr,
	input  wire logic [31:0] dst_addr,
	input  wire logic [15:0] src_port,
	input  wire logic [15:0] dst_port,
	input  wire logic        syn_flag,
	input  wire logic        ack_flag,
	output logic             done,
	output logic [2:0]       event_res,
	output logic [31:0]      client_addr,
	output logic [15:0]      client_port,
	output logic [31:0]      server_addr,
	output logic [15:0]      server_port,
	output logic [31:0]      fail_total
);

	localparam int unsigned CIDX_W = $clog2(CONN_ENTRIES);
	localparam int unsigned FIDX_W = $clog2(FAIL_ENTRIES);
	localparam int unsigned IDX_W  = (CIDX_W > FIDX_W) ? CIDX_W : FIDX_W;
	localparam int unsigned CNT_W  = IDX_W + 1;

	state_t state_q;

	// item key
	logic [31:0] ca_q, sa_q;
	logic [15:0] cp_q, sp_q;
	phase_t      pkt_q;

	// scan counter and compare stage
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] limit;
	logic             vld_s1;
	logic             used_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             hit_q, free_q;
	logic [CIDX_W-1:0] cslot_q;
	logic [FIDX_W-1:0] fslot_q;
	logic [IDX_W-1:0]  free_idx_q;
	phase_t            st_q;
	logic [31:0]       cnt_val_q;

	logic [CONN_ENTRIES-1:0] conn_used_q;
	logic [FAIL_ENTRIES-1:0] fail_used_q;

	conn_entry_t conn_mem [CONN_ENTRIES];
	fail_entry_t fail_mem [FAIL_ENTRIES];
	conn_entry_t conn_rd_s1;
	fail_entry_t fail_rd_s1;

	logic        conn_we, fail_we;
	logic [CIDX_W-1:0] conn_waddr;
	logic [FIDX_W-1:0] fail_waddr;
	conn_entry_t conn_wdata;
	fail_entry_t fail_wdata;

	logic        match;
	logic        failed;
	logic        scan_end;
	logic [31:0] cnt_inc;

	assign busy  = (state_q != S_IDLE);
	assign limit = (state_q == S_FSCAN) ? CNT_W'(FAIL_ENTRIES) : CNT_W'(CONN_ENTRIES);
	assign scan_end = (cnt_q == limit) && !vld_s1;

	// one shared key compare, steered by which table is being scanned
	always_comb begin
		if (state_q == S_FSCAN) begin
			match = (fail_rd_s1.addrs == {ca_q, sa_q}) && (fail_rd_s1.port == sp_q);
		end else begin
			match = (conn_rd_s1.addrs == {ca_q, sa_q}) &&
			        (conn_rd_s1.ports == {cp_q, sp_q});
		end
	end

	always_comb begin
		case (pkt_q)
			PH_REQ:   failed = (st_q != PH_EST);
			PH_REPLY: failed = (st_q != PH_REQ);
			default:  failed = (st_q == PH_REQ);
		endcase
	end

	assign cnt_inc = (cnt_val_q == 32'hFFFF_FFFF) ? cnt_val_q : cnt_val_q + 32'd1;

	// table writes
	always_comb begin
		conn_we    = 1'b0;
		conn_waddr = cslot_q;
		conn_wdata = '{addrs: {ca_q, sa_q}, ports: {cp_q, sp_q}, phase: pkt_q};
		fail_we    = 1'b0;
		fail_waddr = fslot_q;
		fail_wdata = '{addrs: {ca_q, sa_q}, port: sp_q, count: 32'd1};
		if (state_q == S_CDEC) begin
			if (hit_q) begin
				conn_we = !failed;
				if (pkt_q == PH_EST) begin
					conn_wdata.phase = (st_q == PH_REPLY) ? PH_EST : st_q;
				end
			end else begin
				conn_waddr = free_idx_q[CIDX_W-1:0];
				conn_we    = free_q && (pkt_q != PH_REPLY);
			end
		end
		if (state_q == S_FDEC) begin
			if (hit_q) begin
				fail_we          = 1'b1;
				fail_wdata.count = cnt_inc;
			end else begin
				fail_waddr = free_idx_q[FIDX_W-1:0];
				fail_we    = free_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (conn_we) begin
			conn_mem[conn_waddr] <= conn_wdata;
		end
		conn_rd_s1 <= conn_mem[cnt_q[CIDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fail_we) begin
			fail_mem[fail_waddr] <= fail_wdata;
		end
		fail_rd_s1 <= fail_mem[cnt_q[FIDX_W-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			if (syn_flag != ack_flag) begin
				ca_q <= src_addr;
				sa_q <= dst_addr;
				cp_q <= src_port;
				sp_q <= dst_port;
			end else begin
				ca_q <= dst_addr;
				sa_q <= src_addr;
				cp_q <= dst_port;
				sp_q <= src_port;
			end
			if (syn_flag && !ack_flag) begin
				pkt_q <= PH_REQ;
			end else if (syn_flag) begin
				pkt_q <= PH_REPLY;
			end else begin
				pkt_q <= PH_EST;
			end
		end
		idx_s1  <= cnt_q[IDX_W-1:0];
		used_s1 <= (state_q == S_FSCAN) ? fail_used_q[cnt_q[FIDX_W-1:0]]
		                                : conn_used_q[cnt_q[CIDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			cslot_q     <= '0;
			fslot_q     <= '0;
			free_idx_q  <= '0;
			st_q        <= PH_REQ;
			cnt_val_q   <= '0;
			conn_used_q <= '0;
			fail_used_q <= '0;
			done        <= 1'b0;
			event_res   <= EV_NONE;
			client_addr <= '0;
			client_port <= '0;
			server_addr <= '0;
			server_port <= '0;
			fail_total  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done <= 1'b0;
					if (start) begin
						state_q <= S_CSCAN;
						cnt_q   <= '0;
						vld_s1  <= 1'b0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
					end
				end
				S_CSCAN, S_FSCAN: begin
					done <= 1'b0;
					if (cnt_q != limit) begin
						cnt_q  <= cnt_q + CNT_W'(1);
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						if (used_s1) begin
							if (match && !hit_q) begin
								hit_q <= 1'b1;
								if (state_q == S_FSCAN) begin
									fslot_q   <= idx_s1[FIDX_W-1:0];
									cnt_val_q <= fail_rd_s1.count;
								end else begin
									cslot_q <= idx_s1[CIDX_W-1:0];
									st_q    <= conn_rd_s1.phase;
								end
							end
						end else if (!free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
					end
					if (scan_end) begin
						state_q <= (state_q == S_FSCAN) ? S_FDEC : S_CDEC;
					end
				end
				S_CDEC: begin
					client_addr <= ca_q;
					client_port <= cp_q;
					server_addr <= sa_q;
					server_port <= sp_q;
					fail_total  <= '0;
					if (hit_q && failed) begin
						// go count the failure; the slot index stays in cslot_q
						state_q   <= S_FSCAN;
						done      <= 1'b0;
						event_res <= EV_NONE;
						cnt_q     <= '0;
						vld_s1    <= 1'b0;
						hit_q     <= 1'b0;
						free_q    <= 1'b0;
					end else begin
						state_q <= S_IDLE;
						done    <= 1'b1;
						if (hit_q) begin
							event_res <= (pkt_q == PH_EST && st_q == PH_REPLY) ?
							             EV_EST : EV_NONE;
						end else if (pkt_q != PH_REPLY) begin
							if (free_q) begin
								conn_used_q[free_idx_q[CIDX_W-1:0]] <= 1'b1;
								event_res <= EV_NONE;
							end else begin
								event_res <= EV_CONN_FULL;
							end
						end else begin
							event_res <= EV_NONE;
						end
					end
				end
				S_FDEC: begin
					state_q <= S_IDLE;
					done    <= 1'b1;
					if (hit_q || free_q) begin
						event_res            <= EV_FAIL;
						fail_total           <= hit_q ? cnt_inc : 32'd1;
						conn_used_q[cslot_q] <= 1'b0;
						if (!hit_q) begin
							fail_used_q[free_idx_q[FIDX_W-1:0]] <= 1'b1;
						end
					end else begin
						event_res  <= EV_FAIL_FULL;
						fail_total <= '0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					done    <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ tb/tb_tcp_handshake_tracker.sv @@
// Testbench for the TCP handshake tracker: queued packet driver, result monitor, table predictor.
`timescale 1ns / 1ps
module tb_tcp_handshake_tracker;
	import tht_pkg::*;

	localparam int unsigned CONN_N = CONN_ENTRIES_DEF;
	localparam int unsigned FAIL_N = FAIL_ENTRIES_DEF;
	localparam int unsigned POOL_N = 24;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic        syn;
		logic        ack;
		logic        idle_ok;
	} packet_t;

	typedef struct packed {
		logic [31:0] ca;
		logic [15:0] cp;
		logic [31:0] sa;
		logic [15:0] sp;
	} flow_key_t;

	typedef struct packed {
		event_t      ev;
		logic [31:0] ca;
		logic [15:0] cp;
		logic [31:0] sa;
		logic [15:0] sp;
		logic [31:0] total;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        done;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic        syn_flag;
	logic        ack_flag;
	logic [2:0]  event_res;
	logic [31:0] client_addr;
	logic [15:0] client_port;
	logic [31:0] server_addr;
	logic [15:0] server_port;
	logic [31:0] fail_total;

	packet_t drv = '0;

	assign src_addr = drv.src_addr;
	assign dst_addr = drv.dst_addr;
	assign src_port = drv.src_port;
	assign dst_port = drv.dst_port;
	assign syn_flag = drv.syn;
	assign ack_flag = drv.ack;

	tcp_handshake_tracker #(
		.CONN_ENTRIES(CONN_N),
		.FAIL_ENTRIES(FAIL_N)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.src_addr   (src_addr),
		.dst_addr   (dst_addr),
		.src_port   (src_port),
		.dst_port   (dst_port),
		.syn_flag   (syn_flag),
		.ack_flag   (ack_flag),
		.done       (done),
		.event_res  (event_res),
		.client_addr(client_addr),
		.client_port(client_port),
		.server_addr(server_addr),
		.server_port(server_port),
		.fail_total (fail_total)
	);

	always #5 clk = ~clk;

	// tracker state as predicted
	bit          conn_live [CONN_N];
	logic [63:0] conn_key_a [CONN_N];
	logic [31:0] conn_key_p [CONN_N];
	phase_t      conn_ph [CONN_N];
	bit          fail_live [FAIL_N];
	logic [63:0] fail_key_a [FAIL_N];
	logic [15:0] fail_key_p [FAIL_N];
	logic [31:0] fail_cnt [FAIL_N];

	packet_t   pending_pkts[$];
	verdict_t  pending_verdicts[$];
	flow_key_t flow_pool [POOL_N];

	int n_queued = 0;
	int n_accepted = 0;
	int n_errors = 0;
	int ev_seen [5];
	int fresh_seq = 0;
	bit allow_idle = 1'b1;
	bit took = 1'b0;
	bit wait_free = 1'b0;
	int gap_left = 0;
	int calm_left = 0;

	// Count one failure; returns 0 when a new entry is needed and none is free.
	function automatic bit log_failure(logic [63:0] addrs, logic [15:0] port,
			output logic [31:0] total);
		int free_slot;
		free_slot = FAIL_N;
		total = '0;
		for (int i = 0; i < FAIL_N; i++) begin
			if (fail_live[i]) begin
				if (fail_key_a[i] == addrs && fail_key_p[i] == port) begin
					if (fail_cnt[i] != 32'hFFFF_FFFF)
						fail_cnt[i] = fail_cnt[i] + 1;
					total = fail_cnt[i];
					return 1'b1;
				end
			end else if (free_slot == FAIL_N) begin
				free_slot = i;
			end
		end
		if (free_slot == FAIL_N)
			return 1'b0;
		fail_live[free_slot] = 1'b1;
		fail_key_a[free_slot] = addrs;
		fail_key_p[free_slot] = port;
		fail_cnt[free_slot] = 32'd1;
		total = 32'd1;
		return 1'b1;
	endfunction

	function automatic verdict_t track_packet(packet_t p);
		verdict_t    r;
		phase_t      pkt_ph;
		phase_t      st;
		logic [63:0] key_a;
		logic [31:0] key_p;
		logic [31:0] tot;
		int          hit;
		int          free_slot;
		bit          failed;
		r.ev = EV_NONE;
		r.total = '0;
		// one of SYN/ACK: packet's own direction, otherwise swapped
		if (p.syn != p.ack) begin
			r.ca = p.src_addr; r.sa = p.dst_addr; r.cp = p.src_port; r.sp = p.dst_port;
		end else begin
			r.ca = p.dst_addr; r.sa = p.src_addr; r.cp = p.dst_port; r.sp = p.src_port;
		end
		if (p.syn && !p.ack)
			pkt_ph = PH_REQ;
		else if (p.syn && p.ack)
			pkt_ph = PH_REPLY;
		else
			pkt_ph = PH_EST;
		key_a = {r.ca, r.sa};
		key_p = {r.cp, r.sp};
		hit = CONN_N;
		free_slot = CONN_N;
		failed = 1'b0;
		for (int i = 0; i < CONN_N; i++) begin
			if (conn_live[i]) begin
				if (hit == CONN_N && conn_key_a[i] == key_a && conn_key_p[i] == key_p)
					hit = i;
			end else if (free_slot == CONN_N) begin
				free_slot = i;
			end
		end
		if (hit != CONN_N) begin
			st = conn_ph[hit];
			case (pkt_ph)
				PH_REQ: begin
					if (st == PH_EST)
						conn_ph[hit] = PH_REQ;
					else
						failed = 1'b1;
				end
				PH_REPLY: begin
					if (st == PH_REQ)
						conn_ph[hit] = PH_REPLY;
					else
						failed = 1'b1;
				end
				default: begin
					if (st == PH_REPLY) begin
						conn_ph[hit] = PH_EST;
						r.ev = EV_EST;
					end else if (st == PH_REQ) begin
						failed = 1'b1;
					end
				end
			endcase
			if (failed) begin
				if (log_failure(key_a, r.sp, tot)) begin
					r.ev = EV_FAIL;
					r.total = tot;
					conn_live[hit] = 1'b0;
				end else begin
					r.ev = EV_FAIL_FULL;
				end
			end
		end else if (pkt_ph != PH_REPLY) begin
			if (free_slot == CONN_N) begin
				r.ev = EV_CONN_FULL;
			end else begin
				conn_live[free_slot] = 1'b1;
				conn_key_a[free_slot] = key_a;
				conn_key_p[free_slot] = key_p;
				conn_ph[free_slot] = pkt_ph;
			end
		end
		return r;
	endfunction

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
			n_errors++;
		end
	endtask

	// monitor: compare results, predict each accepted item
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n) begin
			if (done) begin
				if (event_res < 5)
					ev_seen[event_res]++;
				if (pending_verdicts.size() == 0) begin
					$display("%0t: result with nothing expected: expected none, actual event %0d",
						$time, event_res);
					n_errors++;
				end else begin
					want = pending_verdicts.pop_front();
					check_field("event_res", 32'(want.ev), 32'(event_res));
					check_field("client_addr", want.ca, client_addr);
					check_field("client_port", 32'(want.cp), 32'(client_port));
					check_field("server_addr", want.sa, server_addr);
					check_field("server_port", 32'(want.sp), 32'(server_port));
					check_field("fail_total", want.total, fail_total);
				end
			end
			if (start && !busy) begin
				pending_verdicts.push_back(track_packet(drv));
				n_accepted++;
			end
		end
		took <= arst_n && start && !busy;
	end

	// driver: one item per start, random gaps before items
	always @(negedge clk) begin
		int mode;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took) begin
			// item still waiting to be taken
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left--;
		end else if (wait_free) begin
			start <= 1'b0;
			if (!busy) begin
				wait_free = 1'b0;
				gap_left = $urandom_range(0, 16);
			end
		end else if (pending_pkts.size() == 0) begin
			start <= 1'b0;
		end else begin
			mode = (pending_pkts[0].idle_ok && calm_left == 0) ? $urandom_range(0, 9) : 9;
			if (mode < 2) begin
				start <= 1'b0;
				gap_left = $urandom_range(0, 16);
			end else if (mode < 4) begin
				// let the block go idle first, then pause
				start <= 1'b0;
				wait_free = 1'b1;
			end else begin
				drv <= pending_pkts.pop_front();
				start <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 31) == 0)
					calm_left = $urandom_range(10, 40);
			end
		end
	end

	task automatic push_pkt(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
			logic [15:0] dp, logic syn, logic ack);
		packet_t p;
		p.src_addr = sa;
		p.dst_addr = da;
		p.src_port = sp;
		p.dst_port = dp;
		p.syn = syn;
		p.ack = ack;
		p.idle_ok = allow_idle;
		pending_pkts.push_back(p);
		n_queued++;
	endtask

	// one packet of the given phase on a connection, sent by the proper side
	task automatic send_phase(flow_key_t k, phase_t ph);
		case (ph)
			PH_REQ:   push_pkt(k.ca, k.sa, k.cp, k.sp, 1'b1, 1'b0);
			PH_REPLY: push_pkt(k.sa, k.ca, k.sp, k.cp, 1'b1, 1'b1);
			default: begin
				if ($urandom_range(0, 1))
					push_pkt(k.ca, k.sa, k.cp, k.sp, 1'b0, 1'b1);
				else
					push_pkt(k.sa, k.ca, k.sp, k.cp, 1'b0, 1'b0);
			end
		endcase
	endtask

	function automatic flow_key_t fresh_flow();
		flow_key_t k;
		fresh_seq++;
		k.ca = {8'hC6, 24'(fresh_seq)};
		k.cp = 16'($urandom);
		k.sa = $urandom;
		k.sp = 16'($urandom);
		return k;
	endfunction

	task automatic rand_traffic(int n);
		int        sent;
		int        r;
		flow_key_t k;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			k = flow_pool[$urandom_range(0, POOL_N - 1)];
			if (r < 20) begin
				send_phase(k, PH_REQ);
				send_phase(k, PH_REPLY);
				send_phase(k, PH_EST);
				sent += 3;
			end else if (r < 85) begin
				send_phase(k, phase_t'($urandom_range(0, 2)));
				sent++;
			end else begin
				push_pkt($urandom, $urandom, 16'($urandom), 16'($urandom),
					1'($urandom), 1'($urandom));
				sent++;
			end
		end
	endtask

	task automatic drain();
		while (n_accepted != n_queued || pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		flow_key_t k0;
		flow_key_t k1;
		flow_key_t k2;
		flow_key_t k3;
		flow_key_t k;
		int        n_free;
		k0 = '{ca: 32'hFFFF_FFFF, cp: 16'hFFFF, sa: 32'h0, sp: 16'h0};
		k1 = '{ca: 32'h0, cp: 16'h0, sa: 32'hFFFF_FFFF, sp: 16'hFFFF};
		k2 = '{ca: $urandom, cp: 16'($urandom), sa: $urandom, sp: 16'($urandom)};
		k3 = k2;
		k3.cp = ~k2.cp;
		// pool: groups of three flows share client, server and server port
		for (int g = 0; g < POOL_N / 3; g++) begin
			k.ca = $urandom;
			k.sa = $urandom;
			k.sp = 16'($urandom);
			for (int j = 0; j < 3; j++) begin
				k.cp = 16'($urandom);
				flow_pool[g * 3 + j] = k;
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// full handshake, repeats, return to request, duplicate SYN failures
		send_phase(k0, PH_REQ);
		send_phase(k0, PH_REPLY);
		push_pkt(k0.ca, k0.sa, k0.cp, k0.sp, 1'b0, 1'b1);
		push_pkt(k0.ca, k0.sa, k0.cp, k0.sp, 1'b0, 1'b1);
		push_pkt(k0.sa, k0.ca, k0.sp, k0.cp, 1'b0, 1'b0);
		send_phase(k0, PH_REQ);
		send_phase(k0, PH_REQ);
		send_phase(k0, PH_REQ);
		send_phase(k0, PH_REQ);
		// reply with no entry, ACK opening an entry, reply on established, reply on reply
		send_phase(k1, PH_REPLY);
		push_pkt(k1.ca, k1.sa, k1.cp, k1.sp, 1'b0, 1'b1);
		send_phase(k1, PH_REPLY);
		send_phase(k1, PH_REQ);
		send_phase(k1, PH_REPLY);
		send_phase(k1, PH_REPLY);
		// established on request, request on reply
		send_phase(k2, PH_REQ);
		push_pkt(k2.sa, k2.ca, k2.sp, k2.cp, 1'b0, 1'b0);
		send_phase(k2, PH_REQ);
		send_phase(k2, PH_REPLY);
		send_phase(k2, PH_REQ);
		// other client port, same failure key
		send_phase(k3, PH_REQ);
		send_phase(k3, PH_REQ);
		// no-flag packet opening an entry, then again
		push_pkt(k3.ca, k3.sa, k3.cp, k3.sp, 1'b0, 1'b0);
		push_pkt(k3.ca, k3.sa, k3.cp, k3.sp, 1'b0, 1'b0);

		rand_traffic(560);

		// fill the connection table, then hit it while full
		drain();
		n_free = 0;
		for (int i = 0; i < CONN_N; i++)
			if (!conn_live[i])
				n_free++;
		for (int i = 0; i < n_free + 3; i++)
			send_phase(fresh_flow(), PH_REQ);
		k = fresh_flow();
		push_pkt(k.ca, k.sa, k.cp, k.sp, 1'b0, 1'b1);
		send_phase(fresh_flow(), PH_REPLY);

		// fail every tracked connection, filling the failure table
		drain();
		for (int i = 0; i < CONN_N; i++) begin
			if (conn_live[i]) begin
				k.ca = conn_key_a[i][63:32];
				k.sa = conn_key_a[i][31:0];
				k.cp = conn_key_p[i][31:16];
				k.sp = conn_key_p[i][15:0];
				send_phase(k, PH_REQ);
				if (conn_ph[i] == PH_EST)
					send_phase(k, PH_REQ);
			end
		end

		// fresh failures until the failure table is full, then an old key again
		drain();
		n_free = 0;
		for (int i = 0; i < FAIL_N; i++)
			if (!fail_live[i])
				n_free++;
		for (int i = 0; i < n_free + 3; i++) begin
			k = fresh_flow();
			send_phase(k, PH_REQ);
			send_phase(k, PH_REQ);
		end
		send_phase(k0, PH_REQ);
		send_phase(k0, PH_REQ);

		// closing stretch without gaps
		allow_idle = 1'b0;
		rand_traffic(60);

		drain();
		repeat (CONN_N + FAIL_N + 16) @(posedge clk);
		$display("Packets: %0d; results: none %0d, established %0d, failed %0d,",
			n_accepted, ev_seen[EV_NONE], ev_seen[EV_EST], ev_seen[EV_FAIL]);
		$display("connection table full %0d, failure table full %0d; mismatches %0d",
			ev_seen[EV_CONN_FULL], ev_seen[EV_FAIL_FULL], n_errors);
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#(50_000_000);
		$display("Timeout: stimulus or results still pending");
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ tcp_handshake_tracker.f @@
sv/tht_pkg.sv
sv/tcp_handshake_tracker.sv
tb/tb_tcp_handshake_tracker.sv
